// ----- hw/rtl/fmrs_pkg.sv -----
// Shared types and constants for the floor-match-remove store.
`timescale 1ns / 1ps

package fmrs_pkg;

  localparam int unsigned CapacityDefault = 256;
  localparam int unsigned ValueW          = 32;
  localparam int unsigned StatusW         = 2;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } opcode_e;

  localparam logic [StatusW-1:0] STATUS_INSERTED = 2'd0;
  localparam logic [StatusW-1:0] STATUS_FULL     = 2'd1;
  localparam logic [StatusW-1:0] STATUS_MATCH    = 2'd2;
  localparam logic [StatusW-1:0] STATUS_NO_MATCH = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } state_e;

  // Broadcast to every cell during the apply cycle.
  typedef struct packed {
    logic              shift_in;   // insert: open a slot and shift up
    logic              shift_out;  // query: drop floor entry and shift down
    logic [ValueW-1:0] item;
  } cell_cmd_t;

endpackage

// ----- hw/rtl/fmrs_cell.sv -----
// One cell of the sorted chain: holds one entry and trades it with its neighbors.
`timescale 1ns / 1ps

module fmrs_cell (
  input  logic                         clk_i,
  input  fmrs_pkg::cell_cmd_t          cmd_i,
  input  logic                         occupied_i,
  input  logic                         prev_le_i,
  input  logic [fmrs_pkg::ValueW-1:0]  prev_value_i,
  input  logic                         next_le_i,
  input  logic [fmrs_pkg::ValueW-1:0]  next_value_i,
  output logic                         le_o,
  output logic [fmrs_pkg::ValueW-1:0]  value_o,
  output logic [fmrs_pkg::ValueW-1:0]  floor_value_o
);

  logic [fmrs_pkg::ValueW-1:0] value_q;
  logic [fmrs_pkg::ValueW-1:0] value_d;
  logic                        le;

  assign le = occupied_i && (value_q <= cmd_i.item);

  always_comb begin
    value_d = value_q;
    if (cmd_i.shift_in && !le) begin
      // first cell above the new item takes it, the rest move up one
      value_d = prev_le_i ? cmd_i.item : prev_value_i;
    end else if (cmd_i.shift_out && !next_le_i) begin
      // floor cell and everything above it move down one
      value_d = next_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign le_o          = le;
  assign value_o       = value_q;
  assign floor_value_o = (le && !next_le_i) ? value_q : '0;

endmodule

// ----- hw/rtl/floor_match_remove_store_unit.sv -----
// Top level of the floor-match-remove store: sorted cell chain, control and result register.
`timescale 1ns / 1ps

// Sorted multiset of up to CAPACITY 32-bit values. s_axis_tuser selects insert (0) or
// query (1); each input transfer produces exactly one result transfer, whose tuser gives
// the status (inserted, full, match, no match) and whose tdata holds the removed floor
// value on a match, else zero. Each item is accepted in the idle state; in the apply
// state every cell compares its entry against the item in parallel and the chain shifts by
// one place, and no new item is accepted until it returns to idle. The apply state waits
// while the result register still holds an untaken result, so back-pressure on the master
// side stalls it. The entry count resets to zero; the cell contents need no clearing, so
// the block is ready right after reset.
module floor_match_remove_store_unit #(
  parameter int unsigned CAPACITY = fmrs_pkg::CapacityDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [fmrs_pkg::ValueW-1:0]   s_axis_tdata,   // [31:0] item_value
  input  logic                          s_axis_tuser,   // [0] opcode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [fmrs_pkg::ValueW-1:0]   m_axis_tdata,   // [31:0] match_value
  output logic [fmrs_pkg::StatusW-1:0]  m_axis_tuser    // [1:0] status
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  fmrs_pkg::state_e                state_q, state_d;
  fmrs_pkg::opcode_e               op_q;
  logic [fmrs_pkg::ValueW-1:0]     item_q;
  logic [CntW-1:0]                 count_q, count_d;
  logic                            m_valid_q;
  logic [fmrs_pkg::StatusW-1:0]    m_status_q;
  logic [fmrs_pkg::ValueW-1:0]     m_value_q;

  logic                            out_free;
  logic                            apply_fire;
  logic                            in_fire;
  logic                            full;
  logic                            have_match;
  fmrs_pkg::cell_cmd_t             cmd;
  logic [fmrs_pkg::StatusW-1:0]    res_status;
  logic [fmrs_pkg::ValueW-1:0]     res_value;
  logic [fmrs_pkg::ValueW-1:0]     floor_any;

  logic [CAPACITY-1:0]             le;
  logic [fmrs_pkg::ValueW-1:0]     value  [CAPACITY];
  logic [fmrs_pkg::ValueW-1:0]     floorv [CAPACITY];

  assign out_free   = !m_valid_q || m_axis_tready;
  assign full       = (count_q == CntW'(CAPACITY));
  // entries are sorted, so any match at all shows up in the lowest cell
  assign have_match = le[0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fmrs_pkg::ST_IDLE: begin
        if (s_axis_tvalid) state_d = fmrs_pkg::ST_APPLY;
      end
      fmrs_pkg::ST_APPLY: begin
        if (out_free) state_d = fmrs_pkg::ST_IDLE;
      end
      default: state_d = fmrs_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    apply_fire    = 1'b0;
    case (state_q)
      fmrs_pkg::ST_IDLE:  s_axis_tready = 1'b1;
      fmrs_pkg::ST_APPLY: apply_fire    = out_free;
      default: begin
        s_axis_tready = 1'b0;
        apply_fire    = 1'b0;
      end
    endcase
  end

  assign in_fire = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cmd.shift_in  = apply_fire && (op_q == fmrs_pkg::OP_INSERT) && !full;
    cmd.shift_out = apply_fire && (op_q == fmrs_pkg::OP_QUERY) && have_match;
    cmd.item      = item_q;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                        prev_le;
    logic [fmrs_pkg::ValueW-1:0] prev_value;
    logic                        next_le;
    logic [fmrs_pkg::ValueW-1:0] next_value;

    if (g == 0) begin : g_first
      assign prev_le    = 1'b1;
      assign prev_value = item_q;
    end else begin : g_mid_lo
      assign prev_le    = le[g-1];
      assign prev_value = value[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign next_le    = 1'b0;
      assign next_value = value[g];
    end else begin : g_mid_hi
      assign next_le    = le[g+1];
      assign next_value = value[g+1];
    end

    fmrs_cell u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .occupied_i    (CntW'(g) < count_q),
      .prev_le_i     (prev_le),
      .prev_value_i  (prev_value),
      .next_le_i     (next_le),
      .next_value_i  (next_value),
      .le_o          (le[g]),
      .value_o       (value[g]),
      .floor_value_o (floorv[g])
    );
  end

  // at most one cell flags itself as the floor; the rest drive zero
  always_comb begin
    floor_any = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      floor_any = floor_any | floorv[i];
    end
  end

  always_comb begin
    res_value = '0;
    if (op_q == fmrs_pkg::OP_INSERT) begin
      res_status = full ? fmrs_pkg::STATUS_FULL : fmrs_pkg::STATUS_INSERTED;
    end else if (have_match) begin
      res_status = fmrs_pkg::STATUS_MATCH;
      res_value  = floor_any;
    end else begin
      res_status = fmrs_pkg::STATUS_NO_MATCH;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd.shift_in)  count_d = count_q + 1'b1;
    if (cmd.shift_out) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fmrs_pkg::ST_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (apply_fire) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= fmrs_pkg::opcode_e'(s_axis_tuser);
      item_q <= s_axis_tdata;
    end
    if (apply_fire) begin
      m_status_q <= res_status;
      m_value_q  <= res_value;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_value_q;
  assign m_axis_tuser  = m_status_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_to_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == fmrs_pkg::ST_APPLY)
    else $error("accepted item did not enter the apply cycle");

  a_sorted_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CntW'(2)) |-> (value[0] <= value[1]))
    else $error("lowest cells out of order");

  a_count_only_on_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> $past(apply_fire))
    else $error("entry count changed outside an apply cycle");

  a_match_removes_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (apply_fire && res_status == fmrs_pkg::STATUS_MATCH)
      |=> count_q == $past(count_q) - 1'b1)
    else $error("match did not remove exactly one entry");
`endif

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the floor-match-remove store unit.
`timescale 1ns / 1ps

module tb;
  import fmrs_pkg::*;

  localparam int unsigned StoreDepth = CapacityDefault;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ValueW-1:0]  value;
  } store_result_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [ValueW-1:0]   s_axis_tdata  = '0;   // [31:0] item_value
  logic                s_axis_tuser  = 1'b0; // [0] opcode
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [ValueW-1:0]   m_axis_tdata;         // [31:0] match_value
  logic [StatusW-1:0]  m_axis_tuser;         // [1:0] status

  // Model of the store contents, kept ascending
  logic [ValueW-1:0] model_entries[$];
  store_result_t     pending_results[$];

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned error_count     = 0;
  int unsigned items_sent      = 0;
  int unsigned results_seen    = 0;
  int unsigned status_hits[4]  = '{0, 0, 0, 0};
  int unsigned hold_left       = 0;
  logic        hold_go         = 1'b0;
  logic        hold_seen       = 1'b0;

  floor_match_remove_store_unit #(
    .CAPACITY(StoreDepth)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  // Insert keeps duplicates; query removes one copy of the largest entry <= limit.
  function automatic store_result_t predict_floor_remove(input opcode_e op,
                                                         input logic [ValueW-1:0] val);
    store_result_t res;
    int            pos;
    res = '0;
    pos = model_entries.size();
    while (pos > 0 && model_entries[pos-1] > val) pos--;
    if (op == OP_INSERT) begin
      if (model_entries.size() >= StoreDepth) begin
        res.status = STATUS_FULL;
      end else begin
        model_entries.insert(pos, val);
        res.status = STATUS_INSERTED;
      end
    end else if (pos == 0) begin
      res.status = STATUS_NO_MATCH;
    end else begin
      res.status = STATUS_MATCH;
      res.value  = model_entries[pos-1];
      model_entries.delete(pos-1);
    end
    return res;
  endfunction

  function automatic logic [ValueW-1:0] pick_value();
    logic [ValueW-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = $urandom_range(63);
      4: begin
        case ($urandom_range(3))
          0: v = '0;
          1: v = '1;
          2: v = 32'h7FFF_FFFF;
          default: v = 32'h8000_0000;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_item(input opcode_e op, input logic [ValueW-1:0] val);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= val;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.insert(pending_results.size(), predict_floor_remove(op, val));
    items_sent++;
  endtask

  // Result side: random stalls, plus a long hold-off counted here
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_go != hold_seen) begin
      hold_left <= 600;
      hold_seen <= hold_go;
    end
    m_axis_tready <= (hold_left == 0) && (hold_go == hold_seen) &&
                     ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    store_result_t exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      status_hits[m_axis_tuser]++;
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result transfer status=%0d value=%h",
                 $time, m_axis_tuser, m_axis_tdata);
      end else begin
        exp_res = pending_results.pop_front();
        if (m_axis_tuser !== exp_res.status) begin
          error_count++;
          $display("%0t: status mismatch expected=%0d actual=%0d",
                   $time, exp_res.status, m_axis_tuser);
        end
        if (m_axis_tdata !== exp_res.value) begin
          error_count++;
          $display("%0t: match_value mismatch expected=%h actual=%h",
                   $time, exp_res.value, m_axis_tdata);
        end
      end
    end
  end

  // Empty store, extremes, duplicates, query below every entry
  task automatic test_directed();
    send_item(OP_QUERY,  32'h0000_0000);
    send_item(OP_QUERY,  32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'd100);
    send_item(OP_QUERY,  32'd99);
    send_item(OP_INSERT, 32'd100);
    send_item(OP_INSERT, 32'h0000_0000);
    send_item(OP_INSERT, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'h8000_0000);
    send_item(OP_INSERT, 32'h5555_5555);
    send_item(OP_INSERT, 32'hAAAA_AAAA);
    send_item(OP_QUERY,  32'd100);
    send_item(OP_QUERY,  32'd100);
    send_item(OP_QUERY,  32'd100);
    send_item(OP_QUERY,  32'hFFFF_FFFE);
    send_item(OP_QUERY,  32'hAAAA_AAA9);
    send_item(OP_QUERY,  32'h5555_5555);
    send_item(OP_QUERY,  32'hFFFF_FFFF);
    send_item(OP_QUERY,  32'hFFFF_FFFF);
    send_item(OP_QUERY,  32'hFFFF_FFFF);
  endtask

  // Fill past capacity so inserts get dropped, then drain part of it
  task automatic test_full_store();
    int fill_count;
    fill_count = StoreDepth - model_entries.size() + 4;
    for (int i = 0; i < fill_count; i++) send_item(OP_INSERT, pick_value());
    for (int i = 0; i < 60; i++) send_item(OP_QUERY, pick_value());
  endtask

  task automatic test_random_mix(input int unsigned n_items);
    int unsigned insert_pct;
    insert_pct = 50;
    for (int i = 0; i < n_items; i++) begin
      // shift the insert/query balance every few dozen items to sweep the fill level
      if (i % 40 == 0) begin
        case ($urandom_range(3))
          0: insert_pct = 25;
          1: insert_pct = 50;
          2: insert_pct = 75;
          default: insert_pct = 92;
        endcase
      end
      if ($urandom_range(99) < insert_pct) send_item(OP_INSERT, pick_value());
      else send_item(OP_QUERY, pick_value());
    end
  endtask

  // Receiver holds off while the sender keeps offering, so input backs up
  task automatic test_backpressure();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_go = ~hold_go;
    for (int i = 0; i < 16; i++) begin
      if (i[0]) send_item(OP_QUERY, pick_value());
      else send_item(OP_INSERT, pick_value());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_store();

    sender_idle_pct = 0;  recv_stall_pct = 0;
    test_random_mix(180);
    sender_idle_pct = 46; recv_stall_pct = 0;
    test_random_mix(180);
    sender_idle_pct = 0;  recv_stall_pct = 46;
    test_random_mix(180);
    sender_idle_pct = 16; recv_stall_pct = 16;
    test_random_mix(180);

    test_backpressure();

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Covered %0d items, %0d results: inserted %0d, dropped full %0d,",
             items_sent, results_seen, status_hits[STATUS_INSERTED],
             status_hits[STATUS_FULL]);
    $display("  matched %0d, no match %0d, across four idle/stall mixes and a long hold-off",
             status_hits[STATUS_MATCH], status_hits[STATUS_NO_MATCH]);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
